// File: src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the buddy block allocator
// item and result structs, queued command format, block metadata word,
// op and status codes, back-end state encoding
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int NumOrdersDef = 10;
    localparam int MinShiftDef  = 4;
    localparam int QueueDepth   = 2;
    localparam int OffW         = 14;
    localparam int SizeW        = 20;
    localparam int OrdW         = 4;
    localparam int MetaBytesW   = 13;

    localparam logic [MetaBytesW-1:0] MetaBytesRst = 13'd704;

    // op codes
    localparam logic [1:0] OP_FORMAT = 2'd0;
    localparam logic [1:0] OP_ALLOC  = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_BLOCK  = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
    localparam logic [2:0] ST_UNALIGNED = 3'd3;
    localparam logic [2:0] ST_FMT_FAIL  = 3'd4;

    typedef struct packed {
        logic [1:0]       op;
        logic [SizeW-1:0] size_bytes;
        logic [OffW-1:0]  block_offset;
    } in_item_t;

    typedef struct packed {
        logic [2:0]      status;
        logic [OffW-1:0] result_offset;
        logic [OrdW-1:0] result_order;
    } out_item_t;

    typedef enum logic [2:0] {
        CMD_FORMAT,
        CMD_ALLOC,
        CMD_FREE,
        CMD_BAD_SIZE,
        CMD_UNALIGNED
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t       kind;
        logic [OrdW-1:0] req;
        logic [OffW-1:0] offset;
    } cmd_t;

    typedef struct packed {
        logic            alloc;
        logic [OrdW-1:0] order;
    } meta_t;

    typedef struct packed {
        logic init_busy;
    } back_stat_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_FMT_CHK,
        S_FMT_TEST,
        S_FMT_PIECE,
        S_FMT_MARK,
        S_FMT_LOOP,
        S_PUSH_A,
        S_PUSH_B,
        S_A_SEARCH,
        S_A_TAKE,
        S_A_TAKE2,
        S_A_SPLIT,
        S_F_RD,
        S_F_CHK,
        S_F_BUD,
        S_F_UN1,
        S_F_UN2,
        S_F_DONE
    } back_state_t;

endpackage

// File: src/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram: generic single-port-write ram
// one write and one read address per cycle, registered read data
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/bba_front.sv
// ----------------------------------------------------------------------------
// bba_front: command classifier
// rounds the size to an order, checks range and alignment, queues the command
// ----------------------------------------------------------------------------
module bba_front #(
    parameter int NUM_ORDERS = bba_pkg::NumOrdersDef,
    parameter int MIN_SHIFT  = bba_pkg::MinShiftDef
) (
    input  logic             accept,
    input  bba_pkg::in_item_t item,
    output logic             q_push,
    output bba_pkg::cmd_t    q_cmd
);

    logic [bba_pkg::SizeW-1:0] size_m1;
    logic [4:0]                hb;
    logic [4:0]                lg;
    logic [4:0]                req5;
    logic                      bad_size;
    logic                      unaligned;

    always_comb
    begin
        size_m1 = item.size_bytes - 20'd1;
        hb = 5'd0;
        for (int i = 0; i < bba_pkg::SizeW; i++)
        begin
            if (size_m1[i])
            begin
                hb = 5'(i);
            end
        end
        // ceiling log2 of the byte count
        lg = (item.size_bytes <= 20'd1) ? 5'd0 : hb + 5'd1;
        req5 = (lg < 5'(MIN_SHIFT)) ? 5'd0 : lg - 5'(MIN_SHIFT);
        bad_size = (item.size_bytes == '0) || (req5 >= 5'(NUM_ORDERS));
        unaligned = (item.block_offset & bba_pkg::OffW'((1 << MIN_SHIFT) - 1)) != '0;

        q_cmd.req = req5[bba_pkg::OrdW-1:0];
        q_cmd.offset = item.block_offset;
        q_push = accept;
        unique case (item.op)
            bba_pkg::OP_FORMAT: q_cmd.kind = bba_pkg::CMD_FORMAT;
            bba_pkg::OP_ALLOC:  q_cmd.kind = bad_size ? bba_pkg::CMD_BAD_SIZE
                                                      : bba_pkg::CMD_ALLOC;
            bba_pkg::OP_FREE:   q_cmd.kind = unaligned ? bba_pkg::CMD_UNALIGNED
                                                       : bba_pkg::CMD_FREE;
            default:
            begin
                // unused op code is dropped
                q_cmd.kind = bba_pkg::CMD_FORMAT;
                q_push = 1'b0;
            end
        endcase
    end

endmodule

// File: src/bba_queue.sv
// ----------------------------------------------------------------------------
// bba_queue: short command fifo between classifier and sequencer
// ----------------------------------------------------------------------------
module bba_queue #(
    parameter int DEPTH = bba_pkg::QueueDepth
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bba_pkg::cmd_t push_cmd,
    input  logic          pop,
    output bba_pkg::cmd_t head_cmd,
    output logic          empty,
    output logic          full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bba_pkg::cmd_t  entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    always_comb
    begin
        do_push = push && !full;
        do_pop = pop && !empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full = (count_reg == CW'(DEPTH));

endmodule

// File: src/bba_back.sv
// ----------------------------------------------------------------------------
// bba_back: allocator sequencer
// walks orders for format, alloc split and free coalesce over the metadata
// and link rams and the per-order list heads
// ----------------------------------------------------------------------------
module bba_back #(
    parameter int NUM_ORDERS = bba_pkg::NumOrdersDef,
    parameter int MIN_SHIFT  = bba_pkg::MinShiftDef
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  bba_pkg::cmd_t                    q_cmd,
    output logic                             q_pop,
    input  logic [bba_pkg::MetaBytesW-1:0]   metadata_bytes,
    output bba_pkg::back_stat_t              stat,
    output logic                             done,
    output bba_pkg::out_item_t               result
);

    localparam int IW    = NUM_ORDERS;
    localparam int Items = 1 << IW;
    localparam int LW    = IW + 1;
    localparam int HW    = $clog2(NUM_ORDERS);
    localparam int OW    = bba_pkg::OffW;
    localparam int MW    = $bits(bba_pkg::meta_t);
    localparam int BW    = bba_pkg::MetaBytesW;

    localparam logic [LW-1:0] Empty  = LW'(Items);
    localparam logic [3:0]    NumOrd = 4'(NUM_ORDERS);
    localparam logic [3:0]    TopOrd = 4'(NUM_ORDERS - 1);
    localparam logic [3:0]    MinSh  = 4'(MIN_SHIFT);

    bba_pkg::back_state_t state_reg, state_next;
    bba_pkg::back_state_t push_ret_reg, push_ret_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   push_idx_reg, push_idx_next;
    logic [IW-1:0]   b_reg, b_next;
    logic [IW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [3:0]      lvl_reg, lvl_next;
    logic [3:0]      ord_reg, ord_next;
    logic [3:0]      req_reg, req_next;
    logic [3:0]      o_reg, o_next;
    logic [3:0]      maxo_reg, maxo_next;
    logic [BW-1:0]   left_reg, left_next;
    logic [LW-1:0]   h_reg, h_next;
    logic [LW-1:0]   pl_reg, pl_next;
    logic [LW-1:0]   nl_reg, nl_next;
    logic            fmt_clr_reg, fmt_clr_next;
    logic [LW-1:0]   heads_reg [NUM_ORDERS];
    logic [LW-1:0]   heads_next [NUM_ORDERS];
    logic            done_reg, done_next;
    bba_pkg::out_item_t result_reg, result_next;

    // ram ports
    logic                m_we;
    logic [IW-1:0]       m_waddr, m_raddr;
    bba_pkg::meta_t      m_wdata;
    logic [MW-1:0]       m_rdata;
    logic                n_we;
    logic [IW-1:0]       n_waddr, n_raddr;
    logic [LW-1:0]       n_wdata, n_rdata;
    logic                p_we;
    logic [IW-1:0]       p_waddr, p_raddr;
    logic [LW-1:0]       p_wdata, p_rdata;

    bba_pkg::meta_t      meta_rd;
    logic [LW-1:0]       head_cur;
    logic [IW-1:0]       lvl_bit;
    logic [3:0]          hb;
    logic [3:0]          o_cur;
    logic [BW-1:0]       left_cur;
    logic [IW-1:0]       bud;
    logic [IW-1:0]       free_idx;
    logic [OW+IW-1:0]    off_wide;

    function automatic logic [OW-1:0] off_of(input logic [IW-1:0] ix);
        logic [OW+IW-1:0] w;
        begin
            w = {{OW{1'b0}}, ix} << MIN_SHIFT;
            return w[OW-1:0];
        end
    endfunction

    bba_ram #(.WIDTH(MW), .DEPTH(Items)) u_meta (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );

    bba_ram #(.WIDTH(LW), .DEPTH(Items)) u_next (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    bba_ram #(.WIDTH(LW), .DEPTH(Items)) u_prev (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    always_comb
    begin
        meta_rd = bba_pkg::meta_t'(m_rdata);
        head_cur = heads_reg[lvl_reg[HW-1:0]];
        lvl_bit = IW'(1) << lvl_reg;
        hb = 4'd0;
        for (int i = 0; i < BW; i++)
        begin
            if (left_reg[i])
            begin
                hb = 4'(i);
            end
        end
        // split off the top power of two of the remaining metadata
        if (hb >= MinSh)
        begin
            left_cur = left_reg - (BW'(1) << hb);
            o_cur = hb - MinSh;
        end
        else
        begin
            left_cur = '0;
            o_cur = 4'd0;
        end
        bud = idx_reg ^ lvl_bit;
        off_wide = {{IW{1'b0}}, q_cmd.offset} >> MIN_SHIFT;
        free_idx = off_wide[IW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        push_ret_next = push_ret_reg;
        idx_next = idx_reg;
        push_idx_next = push_idx_reg;
        b_next = b_reg;
        clr_cnt_next = clr_cnt_reg;
        lvl_next = lvl_reg;
        ord_next = ord_reg;
        req_next = req_reg;
        o_next = o_reg;
        maxo_next = maxo_reg;
        left_next = left_reg;
        h_next = h_reg;
        pl_next = pl_reg;
        nl_next = nl_reg;
        fmt_clr_next = fmt_clr_reg;
        heads_next = heads_reg;
        done_next = 1'b0;
        result_next = result_reg;
        q_pop = 1'b0;

        m_we = 1'b0;
        m_waddr = idx_reg;
        m_wdata = '{alloc: 1'b0, order: 4'd0};
        m_raddr = idx_reg;
        n_we = 1'b0;
        n_waddr = idx_reg;
        n_wdata = Empty;
        n_raddr = idx_reg;
        p_we = 1'b0;
        p_waddr = idx_reg;
        p_wdata = Empty;
        p_raddr = idx_reg;

        unique case (state_reg)
            bba_pkg::S_CLEAR:
            begin
                m_we = 1'b1;
                m_waddr = clr_cnt_reg;
                n_we = 1'b1;
                n_waddr = clr_cnt_reg;
                n_wdata = '0;
                p_we = 1'b1;
                p_waddr = clr_cnt_reg;
                p_wdata = '0;
                for (int k = 0; k < NUM_ORDERS; k++)
                begin
                    heads_next[k] = Empty;
                end
                clr_cnt_next = clr_cnt_reg + IW'(1);
                if (clr_cnt_reg == IW'(Items - 1))
                begin
                    fmt_clr_next = 1'b0;
                    state_next = fmt_clr_reg ? bba_pkg::S_FMT_CHK : bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.kind)
                        bba_pkg::CMD_FORMAT:
                        begin
                            fmt_clr_next = 1'b1;
                            clr_cnt_next = '0;
                            state_next = bba_pkg::S_CLEAR;
                        end
                        bba_pkg::CMD_ALLOC:
                        begin
                            lvl_next = q_cmd.req;
                            req_next = q_cmd.req;
                            state_next = bba_pkg::S_A_SEARCH;
                        end
                        bba_pkg::CMD_FREE:
                        begin
                            idx_next = free_idx;
                            m_raddr = free_idx;
                            state_next = bba_pkg::S_F_RD;
                        end
                        bba_pkg::CMD_BAD_SIZE:
                        begin
                            done_next = 1'b1;
                            result_next = '{status: bba_pkg::ST_BAD_SIZE,
                                            result_offset: '0, result_order: '0};
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            result_next = '{status: bba_pkg::ST_UNALIGNED,
                                            result_offset: '0, result_order: '0};
                        end
                    endcase
                end
            end
            bba_pkg::S_FMT_CHK:
            begin
                left_next = metadata_bytes;
                idx_next = '0;
                maxo_next = NumOrd;
                state_next = bba_pkg::S_FMT_TEST;
            end
            bba_pkg::S_FMT_TEST:
            begin
                // first piece must be nonempty and no larger than the top order
                if ((left_reg == '0) || (o_cur >= NumOrd))
                begin
                    done_next = 1'b1;
                    result_next = '{status: bba_pkg::ST_FMT_FAIL,
                                    result_offset: '0, result_order: '0};
                    state_next = bba_pkg::S_IDLE;
                end
                else
                begin
                    state_next = bba_pkg::S_FMT_PIECE;
                end
            end
            bba_pkg::S_FMT_PIECE:
            begin
                left_next = left_cur;
                o_next = o_cur;
                lvl_next = (left_cur != '0) ? o_cur + 4'd1 : o_cur;
                m_raddr = idx_reg;
                state_next = bba_pkg::S_FMT_MARK;
            end
            bba_pkg::S_FMT_MARK:
            begin
                m_we = 1'b1;
                m_waddr = idx_reg;
                m_wdata = '{alloc: 1'b1, order: meta_rd.order};
                state_next = bba_pkg::S_FMT_LOOP;
            end
            bba_pkg::S_FMT_LOOP:
            begin
                if (lvl_reg < maxo_reg)
                begin
                    push_idx_next = idx_reg + lvl_bit;
                    push_ret_next = bba_pkg::S_FMT_LOOP;
                    state_next = bba_pkg::S_PUSH_A;
                end
                else
                begin
                    idx_next = idx_reg + (IW'(1) << o_reg);
                    maxo_next = o_reg;
                    if (left_reg == '0)
                    begin
                        done_next = 1'b1;
                        result_next = '{status: bba_pkg::ST_OK,
                                        result_offset: '0, result_order: '0};
                        state_next = bba_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = bba_pkg::S_FMT_PIECE;
                    end
                end
            end
            bba_pkg::S_PUSH_A:
            begin
                h_next = head_cur;
                m_we = 1'b1;
                m_waddr = push_idx_reg;
                m_wdata = '{alloc: 1'b0, order: lvl_reg};
                n_we = 1'b1;
                n_waddr = push_idx_reg;
                n_wdata = head_cur;
                p_we = 1'b1;
                p_waddr = push_idx_reg;
                p_wdata = Empty;
                heads_next[lvl_reg[HW-1:0]] = {1'b0, push_idx_reg};
                state_next = bba_pkg::S_PUSH_B;
            end
            bba_pkg::S_PUSH_B:
            begin
                if (h_reg != Empty)
                begin
                    p_we = 1'b1;
                    p_waddr = h_reg[IW-1:0];
                    p_wdata = {1'b0, push_idx_reg};
                end
                lvl_next = lvl_reg + 4'd1;
                state_next = push_ret_reg;
            end
            bba_pkg::S_A_SEARCH:
            begin
                if (lvl_reg >= NumOrd)
                begin
                    done_next = 1'b1;
                    result_next = '{status: bba_pkg::ST_NO_BLOCK,
                                    result_offset: '0, result_order: '0};
                    state_next = bba_pkg::S_IDLE;
                end
                else if (head_cur != Empty)
                begin
                    idx_next = head_cur[IW-1:0];
                    n_raddr = head_cur[IW-1:0];
                    state_next = bba_pkg::S_A_TAKE;
                end
                else
                begin
                    lvl_next = lvl_reg + 4'd1;
                end
            end
            bba_pkg::S_A_TAKE:
            begin
                heads_next[lvl_reg[HW-1:0]] = n_rdata;
                if (n_rdata != Empty)
                begin
                    p_we = 1'b1;
                    p_waddr = n_rdata[IW-1:0];
                    p_wdata = Empty;
                end
                n_we = 1'b1;
                n_waddr = idx_reg;
                n_wdata = Empty;
                m_we = 1'b1;
                m_waddr = idx_reg;
                m_wdata = '{alloc: 1'b1, order: req_reg};
                ord_next = lvl_reg;
                lvl_next = req_reg;
                state_next = bba_pkg::S_A_TAKE2;
            end
            bba_pkg::S_A_TAKE2:
            begin
                p_we = 1'b1;
                p_waddr = idx_reg;
                p_wdata = Empty;
                state_next = bba_pkg::S_A_SPLIT;
            end
            bba_pkg::S_A_SPLIT:
            begin
                if (lvl_reg < ord_reg)
                begin
                    push_idx_next = idx_reg + lvl_bit;
                    push_ret_next = bba_pkg::S_A_SPLIT;
                    state_next = bba_pkg::S_PUSH_A;
                end
                else
                begin
                    done_next = 1'b1;
                    result_next = '{status: bba_pkg::ST_OK,
                                    result_offset: off_of(idx_reg), result_order: req_reg};
                    state_next = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_F_RD:
            begin
                m_we = 1'b1;
                m_waddr = idx_reg;
                m_wdata = '{alloc: 1'b0, order: meta_rd.order};
                lvl_next = (meta_rd.order >= NumOrd) ? TopOrd : meta_rd.order;
                state_next = bba_pkg::S_F_CHK;
            end
            bba_pkg::S_F_CHK:
            begin
                if (lvl_reg < TopOrd)
                begin
                    b_next = bud;
                    m_raddr = bud;
                    n_raddr = bud;
                    p_raddr = bud;
                    state_next = bba_pkg::S_F_BUD;
                end
                else
                begin
                    // top order: no larger block to merge into
                    push_idx_next = idx_reg;
                    push_ret_next = bba_pkg::S_F_DONE;
                    state_next = bba_pkg::S_PUSH_A;
                end
            end
            bba_pkg::S_F_BUD:
            begin
                if (meta_rd.alloc || (meta_rd.order != lvl_reg))
                begin
                    push_idx_next = idx_reg;
                    push_ret_next = bba_pkg::S_F_DONE;
                    state_next = bba_pkg::S_PUSH_A;
                end
                else
                begin
                    pl_next = p_rdata;
                    nl_next = n_rdata;
                    state_next = bba_pkg::S_F_UN1;
                end
            end
            bba_pkg::S_F_UN1:
            begin
                if (pl_reg != Empty)
                begin
                    n_we = 1'b1;
                    n_waddr = pl_reg[IW-1:0];
                    n_wdata = nl_reg;
                end
                if (nl_reg != Empty)
                begin
                    p_we = 1'b1;
                    p_waddr = nl_reg[IW-1:0];
                    p_wdata = pl_reg;
                end
                if (head_cur == {1'b0, b_reg})
                begin
                    heads_next[lvl_reg[HW-1:0]] = nl_reg;
                end
                state_next = bba_pkg::S_F_UN2;
            end
            bba_pkg::S_F_UN2:
            begin
                n_we = 1'b1;
                n_waddr = b_reg;
                n_wdata = Empty;
                p_we = 1'b1;
                p_waddr = b_reg;
                p_wdata = Empty;
                // left buddy survives, right one keeps the order
                m_we = 1'b1;
                m_waddr = (b_reg < idx_reg) ? idx_reg : b_reg;
                m_wdata = '{alloc: 1'b0, order: lvl_reg};
                idx_next = (b_reg < idx_reg) ? b_reg : idx_reg;
                lvl_next = lvl_reg + 4'd1;
                state_next = bba_pkg::S_F_CHK;
            end
            bba_pkg::S_F_DONE:
            begin
                done_next = 1'b1;
                result_next = '{status: bba_pkg::ST_OK,
                                result_offset: off_of(idx_reg),
                                result_order: lvl_reg - 4'd1};
                state_next = bba_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::S_CLEAR;
            push_ret_reg <= bba_pkg::S_IDLE;
            clr_cnt_reg <= '0;
            fmt_clr_reg <= 1'b0;
            done_reg <= 1'b0;
            for (int k = 0; k < NUM_ORDERS; k++)
            begin
                heads_reg[k] <= Empty;
            end
        end
        else
        begin
            state_reg <= state_next;
            push_ret_reg <= push_ret_next;
            clr_cnt_reg <= clr_cnt_next;
            fmt_clr_reg <= fmt_clr_next;
            done_reg <= done_next;
            heads_reg <= heads_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        push_idx_reg <= push_idx_next;
        b_reg <= b_next;
        lvl_reg <= lvl_next;
        ord_reg <= ord_next;
        req_reg <= req_next;
        o_reg <= o_next;
        maxo_reg <= maxo_next;
        left_reg <= left_next;
        h_reg <= h_next;
        pl_reg <= pl_next;
        nl_reg <= nl_next;
        result_reg <= result_next;
    end

    assign stat.init_busy = (state_reg == bba_pkg::S_CLEAR) && !fmt_clr_reg;
    assign done = done_reg;
    assign result = result_reg;

endmodule

// File: src/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator: buddy allocator over one chunk of minimum blocks
// format, allocate and free with per-order doubly linked free lists
// ----------------------------------------------------------------------------
//  channel   | signals                        | beat taken when
//  ----------+--------------------------------+-----------------------------
//  command   | start, busy, item              | start && !busy at clk rise
//  result    | done, result                   | done high, one cycle, no stall
//  config    | cfg_valid, cfg_ready, cfg_data | cfg_valid && cfg_ready
//
//  steps: alloc searches the orders, then splits; free merges buddies;
//  format sweeps the tables, then marks each metadata piece and pushes
//  its leftover buddies; each table has a single write port
//  reset: a clearing pass sweeps every entry of the metadata and
//  link rams; busy stays high through it, config writes still taken
//  stalls: a two-beat command queue lets commands in while the sequencer
//  works; busy rises when it is full; results cannot be held off
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
    parameter int NUM_ORDERS = bba_pkg::NumOrdersDef,
    parameter int MIN_SHIFT  = bba_pkg::MinShiftDef
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // command beat
    input  logic                            start,
    output logic                            busy,
    input  bba_pkg::in_item_t               item,
    // result beat
    output logic                            done,
    output bba_pkg::out_item_t              result,
    // config write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bba_pkg::MetaBytesW-1:0]  cfg_data
);

    logic [bba_pkg::MetaBytesW-1:0] metadata_bytes_reg;
    logic [bba_pkg::MetaBytesW-1:0] metadata_bytes_next;

    logic                 accept;
    logic                 q_push;
    bba_pkg::cmd_t        q_in_cmd;
    bba_pkg::cmd_t        q_head_cmd;
    logic                 q_pop;
    logic                 q_empty;
    logic                 q_full;
    bba_pkg::back_stat_t  stat;

    // config register, always ready
    assign cfg_ready = 1'b1;

    always_comb
    begin
        metadata_bytes_next = metadata_bytes_reg;
        if (cfg_valid && cfg_ready)
        begin
            metadata_bytes_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metadata_bytes_reg <= bba_pkg::MetaBytesRst;
        end
        else
        begin
            metadata_bytes_reg <= metadata_bytes_next;
        end
    end

    // command accepted when the queue has room and the reset sweep is over
    assign busy = q_full || stat.init_busy;
    assign accept = start && !busy;

    bba_front #(
        .NUM_ORDERS(NUM_ORDERS),
        .MIN_SHIFT(MIN_SHIFT)
    ) u_front (
        .accept(accept),
        .item(item),
        .q_push(q_push),
        .q_cmd(q_in_cmd)
    );

    bba_queue #(
        .DEPTH(bba_pkg::QueueDepth)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .push_cmd(q_in_cmd),
        .pop(q_pop),
        .head_cmd(q_head_cmd),
        .empty(q_empty),
        .full(q_full)
    );

    // sequencer owns the tables and drives the result beat
    bba_back #(
        .NUM_ORDERS(NUM_ORDERS),
        .MIN_SHIFT(MIN_SHIFT)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_empty(q_empty),
        .q_cmd(q_head_cmd),
        .q_pop(q_pop),
        .metadata_bytes(metadata_bytes_reg),
        .stat(stat),
        .done(done),
        .result(result)
    );

    // no result during the reset sweep
    a_no_done_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        stat.init_busy |-> !done)
        else $error("result beat during reset sweep");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status <= bba_pkg::ST_FMT_FAIL))
        else $error("status code out of range");

    // failed commands carry zero offset and order
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != bba_pkg::ST_OK)) |->
        ((result.result_offset == '0) && (result.result_order == '0)))
        else $error("failed command with nonzero payload");

endmodule
